/* hdl/mar_pkg.sv */
package mar_pkg;

   // command codes carried in req_cmd
   localparam logic [1:0] CMD_CHECK       = 2'd0;
   localparam logic [1:0] CMD_LOAD_TIME   = 2'd1;
   localparam logic [1:0] CMD_LOAD_OFFSET = 2'd2;
   localparam logic [1:0] CMD_SET_COUNT   = 2'd3;

   // day lengths
   localparam logic [10:0] DAY_MIN = 11'd1440;
   localparam logic [16:0] DAY_SEC = 17'd86400;

   // stored value limits
   localparam logic [10:0] OFFSET_MAX = 11'd2047;
   localparam logic [3:0]  COUNT_MAX  = 4'd15;

   // rounding bias for the nearest minute
   localparam logic [17:0] HALF_MIN_SEC = 18'd30;

   // floor(x / 60) = (x * DIV60_RECIP) >> DIV60_SHIFT, exact for x below 2**18
   localparam logic [18:0] DIV60_RECIP = 19'd279621;
   localparam int          DIV60_SHIFT = 24;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SLOT,
      ST_ALARM,
      ST_REMIND,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic load;
      logic calc_pmin;
      logic alarm_step;
      logic rem_step;
      logic next_slot;
      logic emit;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_check;
      logic slot_on;
      logic last_slot;
      logic alarm_hit;
      logic has_rem;
      logic rem_hit;
      logic rem_last;
      logic found;
      logic out_free;
   } dp_sts_type;

endpackage

/* hdl/mar_ctrl.sv */
module mar_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  mar_pkg::dp_sts_type sts,
   output mar_pkg::dp_cmd_type cmd,
   output logic                req_stall
);

   mar_pkg::state_type state_ff;
   mar_pkg::state_type state_in;

   logic slot_done;

   // a slot's reminder scan is finished once a reminder fired or its list ran out
   assign slot_done = sts.rem_hit || sts.rem_last;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mar_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mar_pkg::ST_IDLE: begin
            if (accept && sts.is_check) begin
               state_in = mar_pkg::ST_SLOT;
            end
         end
         mar_pkg::ST_SLOT: begin
            if (sts.slot_on) begin
               state_in = mar_pkg::ST_ALARM;
            end else if (sts.last_slot) begin
               state_in = mar_pkg::ST_FINISH;
            end
         end
         mar_pkg::ST_ALARM: begin
            if (!sts.found && !sts.alarm_hit && sts.has_rem) begin
               state_in = mar_pkg::ST_REMIND;
            end else if (sts.last_slot) begin
               state_in = mar_pkg::ST_FINISH;
            end else begin
               state_in = mar_pkg::ST_SLOT;
            end
         end
         mar_pkg::ST_REMIND: begin
            if (slot_done) begin
               state_in = sts.last_slot ? mar_pkg::ST_FINISH : mar_pkg::ST_SLOT;
            end
         end
         mar_pkg::ST_FINISH: begin
            if (sts.out_free) begin
               state_in = mar_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mar_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         mar_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.start = accept && sts.is_check;
            cmd.load  = accept && !sts.is_check;
         end
         mar_pkg::ST_SLOT: begin
            cmd.calc_pmin = sts.slot_on;
            cmd.next_slot = !sts.slot_on && !sts.last_slot;
         end
         mar_pkg::ST_ALARM: begin
            cmd.alarm_step = 1'b1;
            cmd.next_slot  = !(!sts.found && !sts.alarm_hit && sts.has_rem) &&
                             !sts.last_slot;
         end
         mar_pkg::ST_REMIND: begin
            cmd.rem_step  = 1'b1;
            cmd.next_slot = slot_done && !sts.last_slot;
         end
         mar_pkg::ST_FINISH: begin
            cmd.emit = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

`ifndef SYNTH
   // reminders are only scanned while no match is held
   a_remind_unmatched: assert property (@(posedge clock) disable iff (reset)
      state_ff == mar_pkg::ST_REMIND |-> !sts.found)
      else $error("reminder scan with a match already held");

   // a load transfer gives no result and keeps the block ready
   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && !sts.is_check) |=> state_ff == mar_pkg::ST_IDLE)
      else $error("load transfer left the idle state");

   // the alarm test always follows the rounding of its slot time
   a_alarm_after_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == mar_pkg::ST_ALARM |-> $past(state_ff) == mar_pkg::ST_SLOT)
      else $error("alarm test without a rounded slot time");

   // a finished result waits while the output register is taken
   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mar_pkg::ST_FINISH && !sts.out_free) |=>
      state_ff == mar_pkg::ST_FINISH)
      else $error("result dropped while output register busy");
`endif

endmodule

/* hdl/mar_datapath.sv */
module mar_datapath #(
   parameter int SLOTS         = 7,
   parameter int MAX_REMINDERS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  mar_pkg::dp_cmd_type cmd,
   output mar_pkg::dp_sts_type sts,
   input  logic [1:0]          req_cmd,
   input  logic [10:0]         req_now_minute,
   input  logic [2:0]          req_slot_index,
   input  logic [2:0]          req_entry_index,
   input  logic [16:0]         req_load_value,
   input  logic                csr_wr_en,
   input  logic [6:0]          csr_wr_data,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic                rsp_match_found,
   output logic [2:0]          rsp_match_slot,
   output logic [10:0]         rsp_lead_minutes,
   output logic [16:0]         rsp_match_time,
   output logic                rsp_next_valid,
   output logic [2:0]          rsp_next_slot,
   output logic [10:0]         rsp_wait_minutes
);

   localparam int ENTRIES = SLOTS * MAX_REMINDERS;
   localparam int SW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int JW      = $clog2(MAX_REMINDERS + 1);

   // table storage
   logic [6:0]         mask_ff;
   logic [16:0]        slot_time_ff [SLOTS];
   logic [3:0]         rem_count_ff [SLOTS];
   logic [10:0]        rem_mem      [ENTRIES];
   logic [ENTRIES-1:0] rem_vld_ff;
   logic [10:0]        rd_data_ff;
   logic               rd_vld_ff;

   // scan registers
   logic [10:0]   now_ff,    now_in;
   logic [16:0]   now60_ff,  now60_in;
   logic [SW-1:0] s_ff,      s_in;
   logic [JW-1:0] j_ff,      j_in;
   logic [11:0]   pmin_ff,   pmin_in;
   logic          found_ff,  found_in;
   logic [SW-1:0] mslot_ff,  mslot_in;
   logic [10:0]   mbefore_ff, mbefore_in;
   logic [16:0]   mtime_ff,  mtime_in;
   logic [16:0]   best_ff,   best_in;
   logic [SW-1:0] nslot_ff,  nslot_in;
   logic          nvalid_ff, nvalid_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_found_ff;
   logic [2:0]  rsp_mslot_ff;
   logic [10:0] rsp_mbefore_ff;
   logic [16:0] rsp_mtime_ff;
   logic        rsp_nvalid_ff;
   logic [2:0]  rsp_nslot_ff;
   logic [10:0] rsp_muntil_ff;

   // load decode
   logic [4:0]    ld_slot5;
   logic [SW-1:0] ld_slot;
   logic          ld_slot_ok;
   logic          ld_entry_ok;
   logic [8:0]    wr_addr9;
   logic [AW-1:0] wr_addr;
   logic          wr_time_en;
   logic          wr_off_en;
   logic          wr_cnt_en;
   logic [10:0]   wr_off_val;
   logic [3:0]    wr_cnt_val;

   assign ld_slot5    = {2'b00, req_slot_index};
   assign ld_slot     = ld_slot5[SW-1:0];
   assign ld_slot_ok  = ld_slot5 < 5'(SLOTS);
   assign ld_entry_ok = {2'b00, req_entry_index} < 5'(MAX_REMINDERS);
   assign wr_addr9    = 9'(ld_slot5) * 9'(MAX_REMINDERS) + 9'(req_entry_index);
   assign wr_addr     = wr_addr9[AW-1:0];
   assign wr_off_val  = (req_load_value > 17'(mar_pkg::OFFSET_MAX)) ?
                        mar_pkg::OFFSET_MAX : req_load_value[10:0];
   assign wr_cnt_val  = (req_load_value > 17'(mar_pkg::COUNT_MAX)) ?
                        mar_pkg::COUNT_MAX : req_load_value[3:0];

   always_comb begin
      wr_time_en = 1'b0;
      wr_off_en  = 1'b0;
      wr_cnt_en  = 1'b0;
      case (req_cmd)
         mar_pkg::CMD_LOAD_TIME:   wr_time_en = cmd.load && ld_slot_ok;
         mar_pkg::CMD_LOAD_OFFSET: wr_off_en  = cmd.load && ld_slot_ok && ld_entry_ok;
         mar_pkg::CMD_SET_COUNT:   wr_cnt_en  = cmd.load && ld_slot_ok;
         default: begin
            wr_time_en = 1'b0;
         end
      endcase
   end

   // enable register
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (csr_wr_en) begin
         mask_ff <= csr_wr_data;
      end
   end

   // slot times and reminder counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_time_ff[i] <= '0;
            rem_count_ff[i] <= '0;
         end
      end else begin
         if (wr_time_en) begin
            slot_time_ff[ld_slot] <= req_load_value;
         end
         if (wr_cnt_en) begin
            rem_count_ff[ld_slot] <= wr_cnt_val;
         end
      end
   end

   // reminder entries; an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_vld_ff <= '0;
      end else if (wr_off_en) begin
         rem_vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_off_en) begin
         rem_mem[wr_addr] <= wr_off_val;
      end
   end

   // current slot view
   logic [16:0]   cur_time;
   logic [3:0]    cur_cnt;
   logic [4:0]    cnt5;
   logic [JW-1:0] cnt_eff;
   logic [4:0]    s5;
   logic          slot_on;

   assign cur_time = slot_time_ff[s_ff];
   assign cur_cnt  = rem_count_ff[s_ff];
   assign cnt5     = {1'b0, cur_cnt};
   assign cnt_eff  = (cnt5 > 5'(MAX_REMINDERS)) ? JW'(MAX_REMINDERS) : cnt5[JW-1:0];
   assign s5       = 5'(s_ff);
   assign slot_on  = (s5 < 5'd7) && mask_ff[s5[2:0]];

   // reminder read: first entry during the alarm test, then one ahead
   logic [JW-1:0] rd_j;
   logic [8:0]    rd_addr9;
   logic [AW-1:0] rd_addr;

   assign rd_j     = cmd.rem_step ? j_ff + JW'(1) : '0;
   assign rd_addr9 = 9'(s_ff) * 9'(MAX_REMINDERS) + 9'(rd_j);
   assign rd_addr  = rd_addr9[AW-1:0];

   always_ff @(posedge clock) begin
      if (rd_addr9 < 9'(ENTRIES)) begin
         rd_data_ff <= rem_mem[rd_addr];
         rd_vld_ff  <= rem_vld_ff[rd_addr];
      end
   end

   // shared divide by 60: rounded slot minute, then minutes until next slot
   logic [17:0] div_x;
   logic [36:0] div_prod;
   logic [11:0] div_q;

   assign div_x    = cmd.emit ? {1'b0, best_ff} : {1'b0, cur_time} + mar_pkg::HALF_MIN_SEC;
   assign div_prod = 37'(div_x) * 37'(mar_pkg::DIV60_RECIP);
   assign div_q    = div_prod[mar_pkg::DIV60_SHIFT +: 12];

   // wrapped seconds until the slot
   logic signed [19:0] d_raw;
   logic signed [19:0] d_wrap;
   logic [17:0]        ahead_sec;

   assign d_raw     = $signed({3'b000, cur_time}) - $signed({3'b000, now60_ff});
   assign d_wrap    = (d_raw < 0) ? d_raw + $signed({3'b000, mar_pkg::DAY_SEC}) : d_raw;
   assign ahead_sec = (d_wrap < 0) ? 18'd0 : d_wrap[17:0];

   // reminder minute with one day of wrap
   logic [10:0]        off;
   logic signed [13:0] r_raw;
   logic signed [13:0] r_wrap;
   logic               alarm_hit;
   logic               rem_hit;

   assign off       = rd_vld_ff ? rd_data_ff : 11'd0;
   assign r_raw     = $signed({2'b00, pmin_ff}) - $signed({3'b000, off});
   assign r_wrap    = (r_raw < 0) ? r_raw + $signed({3'b000, mar_pkg::DAY_MIN}) : r_raw;
   assign rem_hit   = r_wrap == $signed({3'b000, now_ff});
   assign alarm_hit = pmin_ff == {1'b0, now_ff};

   // scan next values
   always_comb begin
      now_in     = now_ff;
      now60_in   = now60_ff;
      s_in       = s_ff;
      j_in       = j_ff;
      pmin_in    = pmin_ff;
      found_in   = found_ff;
      mslot_in   = mslot_ff;
      mbefore_in = mbefore_ff;
      mtime_in   = mtime_ff;
      best_in    = best_ff;
      nslot_in   = nslot_ff;
      nvalid_in  = nvalid_ff;
      if (cmd.start) begin
         now_in     = req_now_minute;
         now60_in   = {req_now_minute, 6'b000000} - {4'b0000, req_now_minute, 2'b00};
         s_in       = '0;
         found_in   = 1'b0;
         mslot_in   = '0;
         mbefore_in = '0;
         mtime_in   = '0;
         best_in    = mar_pkg::DAY_SEC;
         nslot_in   = '0;
         nvalid_in  = 1'b0;
      end
      if (cmd.calc_pmin) begin
         pmin_in = div_q;
      end
      // nearest slot ahead, then the alarm itself
      if (cmd.alarm_step) begin
         j_in = '0;
         if (ahead_sec < {1'b0, best_ff}) begin
            best_in   = ahead_sec[16:0];
            nslot_in  = s_ff;
            nvalid_in = 1'b1;
         end
         if (!found_ff && alarm_hit) begin
            found_in   = 1'b1;
            mslot_in   = s_ff;
            mbefore_in = '0;
            mtime_in   = cur_time;
         end
      end
      // one reminder entry
      if (cmd.rem_step) begin
         j_in = j_ff + JW'(1);
         if (rem_hit) begin
            found_in   = 1'b1;
            mslot_in   = s_ff;
            mbefore_in = off;
            mtime_in   = cur_time;
         end
      end
      if (cmd.next_slot) begin
         s_in = s_ff + SW'(1);
      end
   end

   always_ff @(posedge clock) begin
      now_ff     <= now_in;
      now60_ff   <= now60_in;
      s_ff       <= s_in;
      j_ff       <= j_in;
      pmin_ff    <= pmin_in;
      found_ff   <= found_in;
      mslot_ff   <= mslot_in;
      mbefore_ff <= mbefore_in;
      mtime_ff   <= mtime_in;
      best_ff    <= best_in;
      nslot_ff   <= nslot_in;
      nvalid_ff  <= nvalid_in;
   end

   // output register: load on emit, drop after the transfer
   logic [4:0] mslot5;
   logic [4:0] nslot5;

   assign mslot5 = 5'(mslot_ff);
   assign nslot5 = 5'(nslot_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_found_ff   <= found_ff;
         rsp_mslot_ff   <= mslot5[2:0];
         rsp_mbefore_ff <= mbefore_ff;
         rsp_mtime_ff   <= mtime_ff;
         rsp_nvalid_ff  <= nvalid_ff;
         rsp_nslot_ff   <= nslot5[2:0];
         rsp_muntil_ff  <= nvalid_ff ? div_q[10:0] : mar_pkg::DAY_MIN;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_match_found  = rsp_found_ff;
   assign rsp_match_slot   = rsp_mslot_ff;
   assign rsp_lead_minutes = rsp_mbefore_ff;
   assign rsp_match_time   = rsp_mtime_ff;
   assign rsp_next_valid   = rsp_nvalid_ff;
   assign rsp_next_slot    = rsp_nslot_ff;
   assign rsp_wait_minutes = rsp_muntil_ff;

   // status to the controller
   assign sts.is_check  = req_cmd == mar_pkg::CMD_CHECK;
   assign sts.slot_on   = slot_on;
   assign sts.last_slot = s_ff == SW'(SLOTS - 1);
   assign sts.alarm_hit = alarm_hit;
   assign sts.has_rem   = cnt_eff != '0;
   assign sts.rem_hit   = rem_hit;
   assign sts.rem_last  = (j_ff + JW'(1)) == cnt_eff;
   assign sts.found     = found_ff;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

endmodule

/* hdl/multi_alarm_reminder_matcher_top.sv */
// Daily alarm table with reminders.
// Input channel (req_*): one transfer per command. Load commands write a slot
// time, a reminder offset or a reminder count in the cycle they are taken and
// give no result. A check command gives one result on the rsp_* channel.
// The csr_* port writes the slot enable mask; write it only while idle.
// A check walks the slots in order: a disabled slot passes through the SLOT
// state only, an enabled one through SLOT, ALARM and then REMIND for each
// reminder entry scanned (the reminder memory has one registered read port);
// the FINISH state then loads the output register. The next command can be
// taken in the cycle rsp_valid rises, so a check can follow once the last
// one has returned to idle. Loads can follow each other back to back.
// req_stall stays high while a check is in progress.
// A finished result sits in the output register while rsp_stall is high; the
// next command is taken meanwhile, and a following check waits at its end
// until the register is free.
// Reset clears the enable mask, slot times, reminder counts and the reminder
// valid bits at once; no clearing pass is needed.
module multi_alarm_reminder_matcher_top #(
   parameter int SLOTS         = 7,
   parameter int MAX_REMINDERS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [10:0] req_now_minute,
   input  logic [2:0]  req_slot_index,
   input  logic [2:0]  req_entry_index,
   input  logic [16:0] req_load_value,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_match_found,
   output logic [2:0]  rsp_match_slot,
   output logic [10:0] rsp_lead_minutes,
   output logic [16:0] rsp_match_time,
   output logic        rsp_next_valid,
   output logic [2:0]  rsp_next_slot,
   output logic [10:0] rsp_wait_minutes
);

   mar_pkg::dp_cmd_type cmd;
   mar_pkg::dp_sts_type sts;
   logic                accept;

   // input transfer
   assign accept = req_valid && !req_stall;

   mar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .sts       (sts),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   mar_datapath #(
      .SLOTS         (SLOTS),
      .MAX_REMINDERS (MAX_REMINDERS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_cmd          (req_cmd),
      .req_now_minute   (req_now_minute),
      .req_slot_index   (req_slot_index),
      .req_entry_index  (req_entry_index),
      .req_load_value   (req_load_value),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_match_found  (rsp_match_found),
      .rsp_match_slot   (rsp_match_slot),
      .rsp_lead_minutes (rsp_lead_minutes),
      .rsp_match_time   (rsp_match_time),
      .rsp_next_valid   (rsp_next_valid),
      .rsp_next_slot    (rsp_next_slot),
      .rsp_wait_minutes (rsp_wait_minutes)
   );

endmodule
